/* design/round_robin_process_scheduler_defines.svh */
// Assertion macros used by the scheduler engine.
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define RRPS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define RRPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define RRPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rrps_pkg.sv */
`timescale 1ns / 1ps

package rrps_pkg;

	localparam int MAX_PROCS_DEF = 16;

	localparam int OP_W   = 2;
	localparam int WORD_W = 16;
	localparam int TIME_W = 24;
	localparam int STAT_W = 3;

	localparam logic [WORD_W-1:0] QUANTUM_RESET = 16'd2;

	// Opcodes of an input item.
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Status codes of a result item.
	localparam logic [STAT_W-1:0] STAT_LOADED   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_REJECTED = 3'd1;
	localparam logic [STAT_W-1:0] STAT_SLICE    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_IDLE     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_ALL_DONE = 3'd4;
	localparam logic [STAT_W-1:0] STAT_CLEARED  = 3'd5;

	typedef struct packed {
		logic [WORD_W-1:0] id;
		logic [WORD_W-1:0] arrival;
		logic [WORD_W-1:0] burst;
		logic [WORD_W-1:0] remaining;
		logic [TIME_W-1:0] first_run;
		logic              started;
	} rrps_entry_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [WORD_W-1:0] proc_id;
		logic [WORD_W-1:0] arrival;
		logic [WORD_W-1:0] burst;
	} rrps_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [WORD_W-1:0] run_id;
		logic [TIME_W-1:0] slice_start;
		logic [WORD_W-1:0] slice_length;
		logic              finished;
		logic [TIME_W-1:0] completion;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [TIME_W-1:0] first_start;
		logic [TIME_W-1:0] time_now;
	} rrps_result_t;

endpackage

/* design/rrps_ram.sv */
`timescale 1ns / 1ps

module rrps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/rrps_engine.sv */
`timescale 1ns / 1ps
`include "round_robin_process_scheduler_defines.svh"

module rrps_engine #(
	parameter int MAX_PROCS = rrps_pkg::MAX_PROCS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  rrps_pkg::rrps_item_t             item,
	input  logic [rrps_pkg::WORD_W-1:0]      quantum,
	output logic                             res_valid,
	input  logic                             res_ready,
	output rrps_pkg::rrps_result_t           res
);

	import rrps_pkg::*;

	localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_RD,
		S_LD_CHK,
		S_SCAN,
		S_EVAL,
		S_RUN,
		S_TURN,
		S_FIN,
		S_EMIT
	} state_t;

	state_t             state_q;
	rrps_item_t         item_q;
	rrps_entry_t        ent_q;
	rrps_result_t       res_q;
	logic [CNT_W-1:0]   loaded_cnt_q;
	logic [CNT_W-1:0]   finished_cnt_q;
	logic [CNT_W-1:0]   sweep_idx_q;
	logic [CNT_W-1:0]   idx_q;
	logic [TIME_W-1:0]  sched_time_q;
	logic [WORD_W-1:0]  len_q;
	logic [TIME_W-1:0]  turn_q;
	logic               pass_ran_q;
	logic               run_begun_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	rrps_entry_t        ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	rrps_entry_t        rdata;

	logic               accept;
	logic [CNT_W-1:0]   idx_m1;
	rrps_entry_t        new_entry;
	rrps_entry_t        upd_entry;
	logic [WORD_W-1:0]  q_eff;
	logic [WORD_W-1:0]  len_next;
	logic               runnable;
	logic [TIME_W:0]    sum_len;
	logic [TIME_W:0]    sum_one;
	logic [TIME_W-1:0]  time_after_len;
	logic [TIME_W-1:0]  time_after_tick;
	logic [TIME_W-1:0]  arr_ext;
	logic [TIME_W-1:0]  burst_ext;
	logic [TIME_W-1:0]  turn_next;
	logic [TIME_W-1:0]  wait_next;

	function automatic rrps_result_t status_only(input logic [STAT_W-1:0] st);
		rrps_result_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign res_valid = (state_q == S_EMIT);

	always_comb begin
		res          = res_q;
		res.time_now = sched_time_q;
	end

	assign idx_m1 = idx_q - CNT_W'(1);

	always_comb begin
		new_entry.id        = item_q.proc_id;
		new_entry.arrival   = item_q.arrival;
		new_entry.burst     = item_q.burst;
		new_entry.remaining = item_q.burst;
		new_entry.first_run = '0;
		new_entry.started   = 1'b0;
	end

	always_comb begin
		upd_entry           = ent_q;
		upd_entry.remaining = ent_q.remaining - len_q;
		upd_entry.started   = 1'b1;
		upd_entry.first_run = ent_q.started ? ent_q.first_run : sched_time_q;
	end

	// A quantum of zero behaves as one.
	assign q_eff    = (quantum == '0) ? WORD_W'(1) : quantum;
	assign len_next = (rdata.remaining <= q_eff) ? rdata.remaining : q_eff;
	assign runnable = (rdata.remaining != '0) && (TIME_W'(rdata.arrival) <= sched_time_q);

	// Schedule time saturates at its all-ones value.
	assign sum_len         = {1'b0, sched_time_q} + (TIME_W + 1)'(len_q);
	assign sum_one         = {1'b0, sched_time_q} + (TIME_W + 1)'(1);
	assign time_after_len  = sum_len[TIME_W] ? '1 : sum_len[TIME_W-1:0];
	assign time_after_tick = sum_one[TIME_W] ? '1 : sum_one[TIME_W-1:0];

	assign arr_ext   = TIME_W'(ent_q.arrival);
	assign burst_ext = TIME_W'(ent_q.burst);
	assign turn_next = (sched_time_q >= arr_ext) ? (sched_time_q - arr_ext) : '0;
	assign wait_next = (turn_q >= burst_ext) ? (turn_q - burst_ext) : '0;

	// Every table access is serialized by the sequencer, so a read never
	// overlaps a pending write to the same entry.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_wdata = new_entry;
		ram_re    = 1'b0;
		ram_raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_LD_RD: begin
				if (idx_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_m1[IDX_W-1:0];
				end
			end
			S_LD_CHK: begin
				ram_we = 1'b1;
				if (rdata.arrival > item_q.arrival) begin
					ram_wdata = rdata;
				end
			end
			S_SCAN: begin
				ram_re = (idx_q < loaded_cnt_q);
			end
			S_RUN: begin
				ram_we    = 1'b1;
				ram_wdata = upd_entry;
			end
			default: begin
			end
		endcase
	end

	rrps_ram #(
		.WIDTH ($bits(rrps_entry_t)),
		.DEPTH (MAX_PROCS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			item_q         <= '0;
			ent_q          <= '0;
			res_q          <= '0;
			loaded_cnt_q   <= '0;
			finished_cnt_q <= '0;
			sweep_idx_q    <= '0;
			idx_q          <= '0;
			sched_time_q   <= '0;
			len_q          <= '0;
			turn_q         <= '0;
			pass_ran_q     <= 1'b0;
			run_begun_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= item;
						unique case (item.opcode)
							OP_LOAD: begin
								if (item.burst == '0 || run_begun_q ||
								    loaded_cnt_q >= CNT_W'(MAX_PROCS)) begin
									res_q   <= status_only(STAT_REJECTED);
									state_q <= S_EMIT;
								end else begin
									res_q   <= '0;
									idx_q   <= loaded_cnt_q;
									state_q <= S_LD_RD;
								end
							end
							OP_STEP: begin
								run_begun_q <= 1'b1;
								if (finished_cnt_q >= loaded_cnt_q) begin
									res_q   <= status_only(STAT_ALL_DONE);
									state_q <= S_EMIT;
								end else begin
									res_q   <= '0;
									idx_q   <= sweep_idx_q;
									state_q <= S_SCAN;
								end
							end
							OP_CLEAR: begin
								loaded_cnt_q   <= '0;
								finished_cnt_q <= '0;
								sweep_idx_q    <= '0;
								sched_time_q   <= '0;
								pass_ran_q     <= 1'b0;
								run_begun_q    <= 1'b0;
								res_q          <= status_only(STAT_CLEARED);
								state_q        <= S_EMIT;
							end
							default: begin
								res_q   <= status_only(STAT_REJECTED);
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_LD_RD: begin
					if (idx_q == '0) begin
						loaded_cnt_q <= loaded_cnt_q + CNT_W'(1);
						res_q.status <= STAT_LOADED;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_LD_CHK;
					end
				end
				S_LD_CHK: begin
					// A later arrival moves up one slot; otherwise the new entry lands here.
					if (rdata.arrival > item_q.arrival) begin
						idx_q   <= idx_m1;
						state_q <= S_LD_RD;
					end else begin
						loaded_cnt_q <= loaded_cnt_q + CNT_W'(1);
						res_q.status <= STAT_LOADED;
						state_q      <= S_EMIT;
					end
				end
				S_SCAN: begin
					if (idx_q >= loaded_cnt_q) begin
						if (pass_ran_q) begin
							idx_q      <= '0;
							pass_ran_q <= 1'b0;
						end else begin
							res_q.status      <= STAT_IDLE;
							res_q.slice_start <= sched_time_q;
							sched_time_q      <= time_after_tick;
							sweep_idx_q       <= '0;
							state_q           <= S_EMIT;
						end
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (runnable) begin
						ent_q   <= rdata;
						len_q   <= len_next;
						state_q <= S_RUN;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_SCAN;
					end
				end
				S_RUN: begin
					res_q.status       <= STAT_SLICE;
					res_q.run_id       <= ent_q.id;
					res_q.slice_start  <= sched_time_q;
					res_q.slice_length <= len_q;
					sched_time_q       <= time_after_len;
					sweep_idx_q        <= idx_q + CNT_W'(1);
					pass_ran_q         <= 1'b1;
					ent_q.first_run    <= upd_entry.first_run;
					if (ent_q.remaining == len_q) begin
						finished_cnt_q <= finished_cnt_q + CNT_W'(1);
						res_q.finished <= 1'b1;
						state_q        <= S_TURN;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_TURN: begin
					res_q.completion  <= sched_time_q;
					res_q.turnaround  <= turn_next;
					res_q.first_start <= ent_q.first_run;
					turn_q            <= turn_next;
					state_q           <= S_FIN;
				end
				S_FIN: begin
					res_q.waiting <= wait_next;
					state_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`RRPS_ASSERT_ALWAYS(a_finished_le_loaded, clk, arst_n, finished_cnt_q <= loaded_cnt_q, "more processes finished than loaded")
	`RRPS_ASSERT_ALWAYS(a_sweep_le_loaded, clk, arst_n, sweep_idx_q <= loaded_cnt_q, "sweep index beyond the table")
	`RRPS_ASSERT_NXT(a_step_begins_run, clk, arst_n, accept && item.opcode == OP_STEP, run_begun_q, "step did not mark the run as begun")
	`RRPS_ASSERT_IMP(a_slice_length_ok, clk, arst_n, state_q == S_RUN, len_q != '0 && len_q <= ent_q.remaining, "slice length out of range")

endmodule

/* design/round_robin_process_scheduler.sv */
// Round-robin process scheduler: one result transaction per input transaction.
// Clear, rejected, unknown and all-done items go straight to the result; a load moves
// each entry with a later arrival up one slot, then writes the new entry; a step scans
// the table from the sweep position, wrapping to the head after a pass that ran, and
// adds turnaround and waiting when a process finishes. Items are taken one at a time.
// Reset clears counters, time and sweep state and sets quantum to 2; the table
// contents need no clearing, since only loaded entries are read.
`timescale 1ns / 1ps

module round_robin_process_scheduler #(
	parameter int MAX_PROCS = rrps_pkg::MAX_PROCS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rrps_pkg::OP_W-1:0]     opcode,
	input  logic [rrps_pkg::WORD_W-1:0]   proc_id,
	input  logic [rrps_pkg::WORD_W-1:0]   arrival,
	input  logic [rrps_pkg::WORD_W-1:0]   burst,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rrps_pkg::STAT_W-1:0]   status,
	output logic [rrps_pkg::WORD_W-1:0]   run_id,
	output logic [rrps_pkg::TIME_W-1:0]   slice_start,
	output logic [rrps_pkg::WORD_W-1:0]   slice_length,
	output logic                          finished,
	output logic [rrps_pkg::TIME_W-1:0]   completion,
	output logic [rrps_pkg::TIME_W-1:0]   turnaround,
	output logic [rrps_pkg::TIME_W-1:0]   waiting,
	output logic [rrps_pkg::TIME_W-1:0]   first_start,
	output logic [rrps_pkg::TIME_W-1:0]   time_now,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rrps_pkg::WORD_W-1:0]   cfg_data
);

	import rrps_pkg::*;

	logic [WORD_W-1:0] quantum_q;
	rrps_item_t        item;
	rrps_result_t      res;
	rrps_result_t      out_q;
	logic              res_valid;
	logic              res_ready;
	logic              out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			quantum_q <= cfg_data;
		end
	end

	always_comb begin
		item.opcode  = opcode;
		item.proc_id = proc_id;
		item.arrival = arrival;
		item.burst   = burst;
	end

	rrps_engine #(
		.MAX_PROCS (MAX_PROCS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.item      (item),
		.quantum   (quantum_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register takes a new result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign run_id       = out_q.run_id;
	assign slice_start  = out_q.slice_start;
	assign slice_length = out_q.slice_length;
	assign finished     = out_q.finished;
	assign completion   = out_q.completion;
	assign turnaround   = out_q.turnaround;
	assign waiting      = out_q.waiting;
	assign first_start  = out_q.first_start;
	assign time_now     = out_q.time_now;

endmodule
